FILE: rtl/afcc_pkg.sv
// Shared types, constants and functions of the frame CRC-16 trailer checker.
package afcc_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;
  localparam logic [7:0]  STAR_CHAR      = 8'h2A;
  localparam logic [2:0]  TRAILER_LEN    = 3'd4;
  localparam logic [4:0]  NOT_HEX        = 5'd16;

  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [7:0] ASCII_9  = 8'h39;
  localparam logic [7:0] ASCII_UA = 8'h41;
  localparam logic [7:0] ASCII_UF = 8'h46;
  localparam logic [7:0] ASCII_LA = 8'h61;
  localparam logic [7:0] ASCII_LF = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISSING  = 3'd2,
    ST_NOT_HEX  = 3'd3,
    ST_MISMATCH = 3'd4
  } afcc_status_t;

  typedef struct packed {
    logic [15:0] running_crc;
    logic [15:0] crc_at_star;
    logic        star_seen;
    logic [2:0]  trailer_count;
    logic [15:0] trailer_value;
    logic        trailer_all_hex;
    logic        any_byte_seen;
  } afcc_state_t;

  typedef struct packed {
    afcc_status_t status;
    logic [15:0]  computed_crc;
    logic [15:0]  received_crc;
  } afcc_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

  // Returns the digit value, or NOT_HEX for any other character.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    priority if (ch >= ASCII_0 && ch <= ASCII_9) begin
      d = ch - ASCII_0;
    end else if (ch >= ASCII_UA && ch <= ASCII_UF) begin
      d = ch - ASCII_UA + HEX_TEN;
    end else if (ch >= ASCII_LA && ch <= ASCII_LF) begin
      d = ch - ASCII_LA + HEX_TEN;
    end else begin
      return NOT_HEX;
    end
    return {1'b0, d[3:0]};
  endfunction

endpackage

FILE: rtl/afcc_step.sv
// Per-word update of the frame state and the verdict for a frame-end word.
module afcc_step (
  input  afcc_pkg::afcc_state_t  cur,
  input  logic [7:0]             data_byte,
  input  logic                   has_byte,
  output afcc_pkg::afcc_state_t  nxt,
  output afcc_pkg::afcc_result_t result
);
  import afcc_pkg::*;

  logic [4:0] nib;
  logic       full;

  assign nib = hex_nibble(data_byte);

  always_comb begin
    nxt = cur;
    if (has_byte) begin
      nxt.any_byte_seen = 1'b1;
      if (data_byte == STAR_CHAR) begin
        nxt.crc_at_star     = cur.running_crc;
        nxt.star_seen       = 1'b1;
        nxt.trailer_count   = 3'd0;
        nxt.trailer_value   = 16'h0000;
        nxt.trailer_all_hex = 1'b1;
      end else if (cur.star_seen && cur.trailer_count < TRAILER_LEN) begin
        if (nib[4]) begin
          nxt.trailer_all_hex = 1'b0;
          nxt.trailer_value   = {cur.trailer_value[11:0], 4'h0};
        end else begin
          nxt.trailer_value   = {cur.trailer_value[11:0], nib[3:0]};
        end
        nxt.trailer_count = cur.trailer_count + 3'd1;
      end
      nxt.running_crc = crc16_byte(cur.running_crc, data_byte);
    end
  end

  assign full = nxt.star_seen && (nxt.trailer_count >= TRAILER_LEN);

  always_comb begin
    result.computed_crc = nxt.star_seen ? nxt.crc_at_star : 16'h0000;
    result.received_crc = (full && nxt.trailer_all_hex) ? nxt.trailer_value : 16'h0000;
    priority if (!nxt.any_byte_seen) begin
      result.status       = ST_EMPTY;
      result.computed_crc = 16'h0000;
      result.received_crc = 16'h0000;
    end else if (!full) begin
      result.status = ST_MISSING;
    end else if (!nxt.trailer_all_hex) begin
      result.status = ST_NOT_HEX;
    end else if (nxt.crc_at_star != nxt.trailer_value) begin
      result.status = ST_MISMATCH;
    end else begin
      result.status = ST_OK;
    end
  end

endmodule

FILE: rtl/ascii_frame_crc16_trailer_check_unit.sv
// The registered verdict is on the master side in the cycle after its tlast word is accepted.
// One word per cycle while s_tready is high; CRC step and verdict both settle in that cycle.
// A verdict not yet taken holds back only the next tlast word; other words keep flowing.
// Reset (synchronous, rst high) clears the frame state and the output valid, sets crc_init
// to 0xFFFF; after each verdict the frame state restarts from the current crc_init.
module ascii_frame_crc16_trailer_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        crc_init_we,
  input  logic [15:0] crc_init_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[2:0], computed_crc[18:3], received_crc[34:19], zeros
);
  import afcc_pkg::*;

  logic         [15:0] crc_init;
  afcc_state_t         frame;
  afcc_state_t         frame_next;
  afcc_result_t        verdict;
  logic                accept;

  afcc_step u_step (
    .cur       (frame),
    .data_byte (s_tdata),
    .has_byte  (s_tuser),
    .nxt       (frame_next),
    .result    (verdict)
  );

  // Only a frame-end word needs the output slot.
  assign s_tready = !m_tvalid || m_tready || !s_tlast;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init              <= CRC_INIT_RESET;
      frame.running_crc     <= CRC_INIT_RESET;
      frame.crc_at_star     <= 16'h0000;
      frame.star_seen       <= 1'b0;
      frame.trailer_count   <= 3'd0;
      frame.trailer_value   <= 16'h0000;
      frame.trailer_all_hex <= 1'b1;
      frame.any_byte_seen   <= 1'b0;
      m_tvalid              <= 1'b0;
    end else begin
      if (crc_init_we) begin
        crc_init <= crc_init_data;
      end
      if (accept) begin
        if (s_tlast) begin
          frame.running_crc     <= crc_init;
          frame.crc_at_star     <= 16'h0000;
          frame.star_seen       <= 1'b0;
          frame.trailer_count   <= 3'd0;
          frame.trailer_value   <= 16'h0000;
          frame.trailer_all_hex <= 1'b1;
          frame.any_byte_seen   <= 1'b0;
        end else begin
          frame <= frame_next;
        end
      end
      if (accept && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      m_tdata <= {5'b00000, verdict.received_crc, verdict.computed_crc, verdict.status};
    end
  end

endmodule

FILE: rtl/afcc_checker.sv
// Port-level checks of the frame CRC-16 trailer checker and their bind.
module afcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import afcc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // A result word only appears after a frame-end word was taken.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result word without a frame end");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_MISMATCH)
    else $error("status code out of range");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ST_EMPTY |-> m_tdata[34:3] == 32'h0)
    else $error("empty frame reports nonzero CRC");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ST_OK |-> m_tdata[18:3] == m_tdata[34:19])
    else $error("ok status with differing CRCs");

endmodule

bind ascii_frame_crc16_trailer_check_unit afcc_checker u_afcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
